// ===== hw/rtl/slst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_pkg
// Shared types and constants for the sorted list store.
// ----------------------------------------------------------------------------
package slst_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 4;
   localparam int VAL_W    = 32;
   localparam int OCNT_W   = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]              operation;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [OCNT_W-1:0]       entry_count;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       start_ins;
      logic       ins_step;
      logic       start_rem;
      logic       rem_step;
      logic       start_rd;
      logic       capture_rd;
      logic       set_status;
      logic [1:0] status_code;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       pos_ok;
      logic       ins_stop;
      logic       rem_last;
      logic       out_free;
   } stat_type;

endpackage

// ===== hw/rtl/slst_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_dp
// Datapath: entry memory, count, walk cursor and output register.
// ----------------------------------------------------------------------------
module slst_dp (
   input  logic              clock,
   input  logic              reset,
   input  slst_pkg::req_type req_data,
   input  slst_pkg::cmd_type cmd,
   output slst_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slst_pkg::rsp_type rsp_data
);

   logic [slst_pkg::VAL_W-1:0] mem [slst_pkg::CAPACITY];

   logic [1:0]                        op_ff;
   logic signed [slst_pkg::VAL_W-1:0] val_ff;
   logic [slst_pkg::POS_W-1:0]        pos_ff;
   logic [slst_pkg::CNT_W-1:0]        count_ff;
   logic [slst_pkg::CNT_W-1:0]        count_in;
   logic [slst_pkg::CNT_W-1:0]        cur_ff;
   logic signed [slst_pkg::VAL_W-1:0] rdata_ff;
   logic signed [slst_pkg::VAL_W-1:0] res_rd_ff;
   logic [1:0]                        res_st_ff;
   logic                              rsp_valid_ff;
   slst_pkg::rsp_type                 rsp_data_ff;

   logic [slst_pkg::IDX_W-1:0]        rd_addr;
   logic                              wr_en;
   logic [slst_pkg::IDX_W-1:0]        wr_addr;
   logic [slst_pkg::VAL_W-1:0]        wr_data;
   logic [slst_pkg::CNT_W:0]          cur_next;
   logic [slst_pkg::CNT_W-1:0]        pos_cnt;

   assign pos_cnt  = slst_pkg::CNT_W'(pos_ff);
   assign cur_next = {1'b0, cur_ff} + (slst_pkg::CNT_W + 1)'(1);

   assign stat.op       = op_ff;
   assign stat.full     = (count_ff == slst_pkg::CNT_W'(slst_pkg::CAPACITY));
   assign stat.pos_ok   = ((slst_pkg::CNT_W + slst_pkg::POS_W)'(pos_ff)
                           < (slst_pkg::CNT_W + slst_pkg::POS_W)'(count_ff));
   assign stat.ins_stop = (cur_ff == '0) || (rdata_ff < val_ff);
   assign stat.rem_last = (cur_next >= {1'b0, count_ff});
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rd_addr = slst_pkg::IDX_W'(pos_ff);
      if (cmd.start_ins) begin
         rd_addr = slst_pkg::IDX_W'(count_ff - slst_pkg::CNT_W'(1));
      end else if (cmd.ins_step) begin
         rd_addr = slst_pkg::IDX_W'(cur_ff - slst_pkg::CNT_W'(2));
      end else if (cmd.start_rem) begin
         rd_addr = slst_pkg::IDX_W'(pos_cnt + slst_pkg::CNT_W'(1));
      end else if (cmd.rem_step) begin
         rd_addr = slst_pkg::IDX_W'(cur_ff + slst_pkg::CNT_W'(2));
      end else if (cmd.start_rd) begin
         rd_addr = slst_pkg::IDX_W'(pos_ff);
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = slst_pkg::IDX_W'(cur_ff);
      wr_data  = rdata_ff;
      count_in = count_ff;
      if (cmd.ins_step) begin
         wr_en = 1'b1;
         if (stat.ins_stop) begin
            wr_data  = val_ff;
            count_in = count_ff + slst_pkg::CNT_W'(1);
         end
      end else if (cmd.rem_step) begin
         if (stat.rem_last) begin
            count_in = count_ff - slst_pkg::CNT_W'(1);
         end else begin
            wr_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.operation;
         val_ff <= req_data.value;
         pos_ff <= req_data.position;
      end
      if (cmd.start_ins) begin
         cur_ff <= count_ff;
      end else if (cmd.start_rem) begin
         cur_ff <= pos_cnt;
      end else if (cmd.ins_step && !stat.ins_stop) begin
         cur_ff <= cur_ff - slst_pkg::CNT_W'(1);
      end else if (cmd.rem_step && !stat.rem_last) begin
         cur_ff <= slst_pkg::CNT_W'(cur_next);
      end
      if (cmd.load) begin
         res_rd_ff <= '0;
         res_st_ff <= slst_pkg::ST_OK;
      end else begin
         if (cmd.capture_rd) begin
            res_rd_ff <= rdata_ff;
         end
         if (cmd.set_status) begin
            res_st_ff <= cmd.status_code;
         end
      end
      if (cmd.push) begin
         rsp_data_ff.read_value  <= res_rd_ff;
         rsp_data_ff.entry_count <= slst_pkg::OCNT_W'(count_ff);
         rsp_data_ff.status      <= res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/slst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_ctrl
// Controller: sequences the insert, remove and read walks.
// ----------------------------------------------------------------------------
module slst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  slst_pkg::stat_type stat,
   output slst_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_INSERT = 3'd2;
   localparam logic [2:0] S_REMOVE = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               slst_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = slst_pkg::ST_FULL;
                     state_in        = S_DONE;
                  end else begin
                     cmd.start_ins = 1'b1;
                     state_in      = S_INSERT;
                  end
               end
               slst_pkg::OP_REMOVE: begin
                  if (!stat.pos_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = slst_pkg::ST_RANGE;
                     state_in        = S_DONE;
                  end else begin
                     cmd.start_rem = 1'b1;
                     state_in      = S_REMOVE;
                  end
               end
               slst_pkg::OP_READ: begin
                  if (!stat.pos_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = slst_pkg::ST_RANGE;
                     state_in        = S_DONE;
                  end else begin
                     cmd.start_rd = 1'b1;
                     state_in     = S_READ;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_INSERT: begin
            cmd.ins_step = 1'b1;
            if (stat.ins_stop) begin
               state_in = S_DONE;
            end
         end
         S_REMOVE: begin
            cmd.rem_step = 1'b1;
            if (stat.rem_last) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            cmd.capture_rd = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/sorted_list_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_store
// Sorted store of signed 32-bit values with insert, remove and read.
// ----------------------------------------------------------------------------
// Request channel (req_): operation, value and position; a transaction is
// taken when req_valid is high and req_stall low. req_stall stays high from
// the cycle after a transaction until its result has entered the output
// register, so one transaction is in work at a time.
// Result channel (rsp_): read_value, entry_count and status from an output
// register; rsp_stall holds it. While a result waits there, the next request
// is still taken and worked on.
// An insert moves up each entry not below the new value, from the top
// (at most 15); a remove moves down each entry above the position (at
// most 15); rejected or unused requests skip the walk. The walk moves one
// entry a cycle through the one read port and one write port of the entry
// memory. The next request is taken once the result of the last one has
// entered the output register.
// Reset clears the count and the result valid; entry contents are not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_list_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slst_pkg::rsp_type rsp_data
);

   slst_pkg::cmd_type  cmd;
   slst_pkg::stat_type stat;

   slst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   slst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sorted_list_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_store_tb
// Self-checking bench for the sorted list store. A short scripted sequence
// covers empty, full and out-of-range cases, the extreme values and equal
// values. Random insert, remove and read traffic follows, with the insert
// share varied so the fill level sweeps between empty and full. Each
// transaction is mirrored in a local copy of the sorted list, and every
// result is compared field by field with the oldest pending expectation.
// Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module sorted_list_store_tb;
   import slst_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         RANDOM_ITEMS = 1900;
   localparam int         QUIET_ITEMS  = 150;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 40;

   typedef struct {
      req_type item;
      bit      fixed_ok;
      rsp_type fixed_rsp;
   } script_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic signed [VAL_W-1:0] stored_vals [CAPACITY];
   int                      stored_count = 0;
   rsp_type                 expected_rsps [$];
   script_row_type          script_rows [$];

   int mismatches  = 0;
   int idle_cycles = 0;
   int idle_odds   = 0;
   int stall_left  = 0;

   sorted_list_store uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mirror of the store: returns the result a transaction should produce
   function automatic rsp_type apply_request(req_type item);
      rsp_type                 res;
      logic signed [VAL_W-1:0] new_val;
      int                      slot;
      res     = '0;
      new_val = item.value;
      slot    = 0;
      case (item.operation)
         OP_INSERT: begin
            if (stored_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               while (slot < stored_count && stored_vals[slot] < new_val) slot++;
               for (int i = stored_count; i > slot; i--) stored_vals[i] = stored_vals[i-1];
               stored_vals[slot] = new_val;
               stored_count++;
               res.status = ST_OK;
            end
         end
         OP_REMOVE: begin
            if (item.position >= stored_count) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = item.position; i + 1 < stored_count; i++)
                  stored_vals[i] = stored_vals[i+1];
               stored_count--;
               res.status = ST_OK;
            end
         end
         OP_READ: begin
            if (item.position < stored_count) begin
               res.read_value = stored_vals[item.position];
               res.status     = ST_OK;
            end else begin
               res.status = ST_RANGE;
            end
         end
         default: res.status = ST_OK;
      endcase
      res.entry_count = OCNT_W'(stored_count);
      return res;
   endfunction

   function automatic void add_row(logic [1:0] op, logic [VAL_W-1:0] val,
                                   logic [POS_W-1:0] pos, bit fixed_ok,
                                   logic [OCNT_W-1:0] cnt, logic [1:0] st);
      script_row_type row;
      row.item.operation       = op;
      row.item.value           = val;
      row.item.position        = pos;
      row.fixed_ok             = fixed_ok;
      row.fixed_rsp.read_value = '0;
      row.fixed_rsp.entry_count = cnt;
      row.fixed_rsp.status     = st;
      script_rows.push_back(row);
   endfunction

   function automatic logic [VAL_W-1:0] random_value();
      logic [VAL_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1: v = VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
         2: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = '0;
               default: v = '1;
            endcase
         end
         3, 4: begin
            if (stored_count > 0) v = stored_vals[$urandom_range(0, stored_count - 1)];
            else v = $urandom();
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic req_type random_item(int insert_pct);
      req_type it;
      int      roll;
      roll     = $urandom_range(0, 99);
      it.value = random_value();
      if (stored_count > 0 && $urandom_range(0, 3) != 0)
         it.position = POS_W'($urandom_range(0, stored_count - 1));
      else
         it.position = POS_W'($urandom_range(0, 15));
      if (roll < 3)
         it.operation = OP_UNUSED;
      else if (roll < 3 + insert_pct)
         it.operation = OP_INSERT;
      else if ($urandom_range(0, 1) == 0)
         it.operation = OP_REMOVE;
      else
         it.operation = OP_READ;
      return it;
   endfunction

   // holds the transaction until taken, then optionally idles
   task automatic send_item(req_type item, bit fixed_ok, rsp_type fixed_rsp);
      rsp_type want;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = apply_request(item);
      if (fixed_ok) want = fixed_rsp;
      expected_rsps.push_back(want);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic walk_rows();
      script_row_type row;
      while (script_rows.size() != 0) begin
         row = script_rows.pop_front();
         send_item(row.item, row.fixed_ok, row.fixed_rsp);
      end
   endtask

   initial begin
      int      random_sent;
      int      segment_left;
      int      insert_pct;
      req_type item;
      random_sent  = 0;
      segment_left = 0;
      insert_pct   = 50;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_odds = 3;
      add_row(OP_READ,   32'h0000_0000, 4'd0,  1, 5'd0, ST_RANGE);
      add_row(OP_REMOVE, 32'h0000_0000, 4'd0,  1, 5'd0, ST_RANGE);
      add_row(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 1, 5'd0, ST_OK);
      add_row(OP_INSERT, 32'h7FFF_FFFF, 4'd0,  1, 5'd1, ST_OK);
      add_row(OP_INSERT, 32'h8000_0000, 4'd0,  1, 5'd2, ST_OK);
      add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1, 5'd3, ST_OK);
      add_row(OP_INSERT, 32'hFFFF_FFFF, 4'd0,  1, 5'd4, ST_OK);
      add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1, 5'd5, ST_OK);
      add_row(OP_INSERT, 32'h7FFF_FFFF, 4'd0,  1, 5'd6, ST_OK);
      add_row(OP_INSERT, 32'h8000_0000, 4'd0,  1, 5'd7, ST_OK);
      add_row(OP_READ,   32'h0000_0000, 4'd0,  0, 5'd0, ST_OK);
      add_row(OP_READ,   32'h0000_0000, 4'd6,  0, 5'd0, ST_OK);
      add_row(OP_READ,   32'h0000_0000, 4'd7,  1, 5'd7, ST_RANGE);
      add_row(OP_READ,   32'h0000_0000, 4'd15, 1, 5'd7, ST_RANGE);
      add_row(OP_REMOVE, 32'h0000_0000, 4'd15, 1, 5'd7, ST_RANGE);
      add_row(OP_REMOVE, 32'h0000_0000, 4'd3,  1, 5'd6, ST_OK);
      add_row(OP_REMOVE, 32'h0000_0000, 4'd0,  1, 5'd5, ST_OK);
      add_row(OP_REMOVE, 32'h0000_0000, 4'd4,  1, 5'd4, ST_OK);
      add_row(OP_READ,   32'h0000_0000, 4'd3,  0, 5'd0, ST_OK);
      add_row(OP_INSERT, 32'h5555_5555, 4'd0,  1, 5'd5, ST_OK);
      add_row(OP_INSERT, 32'hAAAA_AAAA, 4'd0,  1, 5'd6, ST_OK);
      add_row(OP_READ,   32'h0000_0000, 4'd0,  0, 5'd0, ST_OK);
      walk_rows();

      // fill to capacity, then hit the full case
      while (stored_count < CAPACITY) begin
         item.operation = OP_INSERT;
         item.value     = random_value();
         item.position  = '0;
         send_item(item, 1'b0, '0);
      end
      add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1, 5'd16, ST_FULL);
      add_row(OP_INSERT, 32'h8000_0000, 4'd0,  1, 5'd16, ST_FULL);
      add_row(OP_READ,   32'h0000_0000, 4'd15, 0, 5'd0,  ST_OK);
      add_row(OP_REMOVE, 32'h0000_0000, 4'd15, 1, 5'd15, ST_OK);
      walk_rows();

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
            idle_odds  = 0;
            insert_pct = 45;
         end else if (segment_left == 0) begin
            segment_left = $urandom_range(30, 70);
            case ($urandom_range(0, 2))
               0:       insert_pct = 20;
               1:       insert_pct = 48;
               default: insert_pct = 80;
            endcase
            case ($urandom_range(0, 3))
               0:       idle_odds = 0;
               1:       idle_odds = 2;
               2:       idle_odds = 5;
               default: idle_odds = 12;
            endcase
         end
         item = random_item(insert_pct);
         send_item(item, 1'b0, '0);
         if (item.operation != OP_UNUSED) begin
            random_sent++;
            if (segment_left > 0) segment_left--;
         end
      end
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if (!reset && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         stall_left = $urandom_range(1, 18);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: value %0d count %0d status %0d",
                        rsp_data.read_value, rsp_data.entry_count, rsp_data.status);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.read_value !== want.read_value ||
                rsp_data.entry_count !== want.entry_count ||
                rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected value %0d count %0d status %0d, ",
                            "got value %0d count %0d status %0d"},
                           want.read_value, want.entry_count, want.status,
                           rsp_data.read_value, rsp_data.entry_count, rsp_data.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
